FILE: src/mse_pkg.sv
`default_nettype none

package mse_pkg;

  // Data memory geometry: depth is a power of two so the word index wraps by masking.
  localparam int unsigned MEM_AW    = 10;
  localparam int unsigned MEM_WORDS = 1 << MEM_AW;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_JALR = 6'h09;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd31;

  // Outcome of executing one instruction
  typedef struct packed {
    logic        err;       // unaligned load/store
    logic        wen;       // general register write, never r0
    logic [4:0]  widx;
    logic [31:0] wval;      // zero for loads; load data comes from memory
    logic        ld;        // load that writes a register
    logic        rd_mem;    // issue a memory read
    logic        st;        // store
    logic [31:0] ea;        // effective byte address
    logic [31:0] sdata;
    logic [31:0] pc_nxt;
    logic        pend_nxt;
    logic [31:0] btgt_nxt;
  } exec_t;

endpackage

`default_nettype wire

FILE: src/mse_exec.sv
`default_nettype none

module mse_exec import mse_pkg::*; (
  input  wire logic [31:0] ins_i,
  input  wire logic [31:0] pc_i,
  input  wire logic [31:0] vrs_i,
  input  wire logic [31:0] vrt_i,
  input  wire logic        pend_i,
  input  wire logic [31:0] btgt_i,
  output exec_t            exec_o
);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sa;
  logic [31:0] simm;
  logic [31:0] ea;
  logic [31:0] jtgt;
  logic [31:0] btgt;
  logic [31:0] pc4;

  logic        wr;
  logic [4:0]  widx;
  logic [31:0] wval;
  logic        taken;
  logic [31:0] tgt;
  logic        ld;
  logic        st;
  logic        err;

  assign op   = ins_i[31:26];
  assign rt   = ins_i[20:16];
  assign rd   = ins_i[15:11];
  assign sa   = ins_i[10:6];
  assign fn   = ins_i[5:0];
  assign simm = {{16{ins_i[15]}}, ins_i[15:0]};
  assign ea   = vrs_i + simm;
  assign pc4  = pc_i + 32'd4;
  assign jtgt = {pc_i[31:28], ins_i[25:0], 2'b00};
  assign btgt = pc4 + {simm[29:0], 2'b00};

  always_comb begin
    wr    = 1'b0;
    widx  = rt;
    wval  = '0;
    taken = 1'b0;
    tgt   = '0;
    ld    = 1'b0;
    st    = 1'b0;
    err   = 1'b0;
    case (op)
      OP_SPECIAL: begin
        wr   = 1'b1;
        widx = rd;
        case (fn)
          FN_SLL: begin
            // all-zero encoding is the NOP
            if (rd == REG_ZERO && rt == REG_ZERO && sa == 5'd0) begin
              wr = 1'b0;
            end else begin
              wval = vrt_i << sa;
            end
          end
          FN_SRL:  wval = vrt_i >> sa;
          FN_SRA:  wval = 32'($signed(vrt_i) >>> sa);
          FN_JR: begin
            wr    = 1'b0;
            taken = 1'b1;
            tgt   = vrs_i;
          end
          FN_JALR: begin
            widx  = (rd == REG_ZERO) ? REG_RA : rd;
            wval  = pc_i + 32'd8;
            taken = 1'b1;
            tgt   = vrs_i;
          end
          FN_SUBU: wval = vrs_i - vrt_i;
          FN_AND:  wval = vrs_i & vrt_i;
          FN_OR:   wval = vrs_i | vrt_i;
          FN_XOR:  wval = vrs_i ^ vrt_i;
          FN_NOR:  wval = ~(vrs_i | vrt_i);
          FN_SLT:  wval = {31'd0, $signed(vrs_i) < $signed(vrt_i)};
          FN_SLTU: wval = {31'd0, vrs_i < vrt_i};
          default: wr = 1'b0;
        endcase
      end
      OP_J: begin
        taken = 1'b1;
        tgt   = jtgt;
      end
      OP_JAL: begin
        wr    = 1'b1;
        widx  = REG_RA;
        wval  = pc_i + 32'd8;
        taken = 1'b1;
        tgt   = jtgt;
      end
      OP_BEQ: begin
        taken = (vrs_i == vrt_i);
        tgt   = btgt;
      end
      OP_BNE: begin
        taken = (vrs_i != vrt_i);
        tgt   = btgt;
      end
      OP_ADDIU: begin
        wr   = 1'b1;
        wval = ea;
      end
      OP_ORI: begin
        wr   = 1'b1;
        wval = vrs_i | {16'd0, ins_i[15:0]};
      end
      OP_LUI: begin
        wr   = 1'b1;
        wval = {ins_i[15:0], 16'd0};
      end
      OP_LW: begin
        if (ea[1:0] != 2'b00) begin
          err = 1'b1;
        end else begin
          wr = 1'b1;
          ld = 1'b1;
        end
      end
      OP_SW: begin
        if (ea[1:0] != 2'b00) begin
          err = 1'b1;
        end else begin
          st = 1'b1;
        end
      end
      default: wr = 1'b0;
    endcase

    exec_o.err    = err;
    exec_o.wen    = wr && (widx != REG_ZERO);
    exec_o.widx   = exec_o.wen ? widx : REG_ZERO;
    exec_o.wval   = (exec_o.wen && !ld) ? wval : '0;
    exec_o.ld     = ld && exec_o.wen;
    exec_o.rd_mem = ld;
    exec_o.st     = st;
    exec_o.ea     = ea;
    exec_o.sdata  = vrt_i;

    // an error keeps all; else resolve pending branch; a slot branch only links
    if (err) begin
      exec_o.pc_nxt   = pc_i;
      exec_o.pend_nxt = pend_i;
      exec_o.btgt_nxt = btgt_i;
    end else if (pend_i) begin
      exec_o.pc_nxt   = btgt_i;
      exec_o.pend_nxt = 1'b0;
      exec_o.btgt_nxt = btgt_i;
    end else begin
      exec_o.pc_nxt   = pc4;
      exec_o.pend_nxt = taken;
      exec_o.btgt_nxt = taken ? tgt : btgt_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/mips_subset_execute_core.sv
`default_nettype none

// Channel   Dir  Handshake              Payload
// -------   ---  ---------------------  ------------------------------------------
// in        in   in_valid_i/in_stall_o  instruction_i
// out       out  out_valid_o/out_stall_i status_o, pc_after_o, reg_*_o, mem_*_o
// cfg       in   cfg_valid_i/cfg_ready_o cfg_start_pc_i (loads the program counter)
//
// One instruction per cycle while out_stall_i is low and no sweep runs. A word
// accepted sits in the operand stage until the result register can load it.
// After reset the data memory is swept to zero, one word per cycle, across all
// MEM_WORDS words; in_stall_o stays high during the sweep, while
// configuration writes are taken at any time.
// A stalled result holds the result register; the operand stage still fills,
// so one more word is taken before in_stall_o rises.

module mips_subset_execute_core import mse_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] instruction_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             status_o,
  output logic [31:0]      pc_after_o,
  output logic             reg_written_o,
  output logic [4:0]       reg_index_o,
  output logic [31:0]      reg_value_o,
  output logic             mem_written_o,
  output logic [31:0]      mem_address_o,
  output logic [31:0]      mem_data_o,

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_start_pc_i
);

  // ---------------------------------------------------------------------------
  // Architectural control state
  // ---------------------------------------------------------------------------
  logic [31:0] pc_q;
  logic        pend_q;
  logic [31:0] btgt_q;

  // ---------------------------------------------------------------------------
  // Operand stage (S1) and result register (S2)
  // ---------------------------------------------------------------------------
  logic        v1_q;
  logic [31:0] ins1_q;

  logic        v2_q;
  logic        fresh_q;   // S2 word has not yet written the register file
  logic        status_q;
  logic [31:0] pc_after_q;
  logic        wen_q;
  logic [4:0]  widx_q;
  logic [31:0] value_q;
  logic        ld_q;
  logic        st_q;
  logic [31:0] maddr_q;
  logic [31:0] mdata_q;

  logic        in_acc;
  logic        s2_load;
  logic        s1_adv;
  logic        cfg_we;

  // ---------------------------------------------------------------------------
  // Register file: two registered read ports, one write port, valid bits
  // ---------------------------------------------------------------------------
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_q;
  logic [31:0] rf_a_q;
  logic [31:0] rf_b_q;
  logic [4:0]  rf_ra;
  logic [4:0]  rf_rb;
  logic        rf_we;
  logic [31:0] wb_val;

  // last register write, covers the read that raced it
  logic        lw_en_q;
  logic [4:0]  lw_idx_q;
  logic [31:0] lw_data_q;

  logic [4:0]  rs1;
  logic [4:0]  rt1;
  logic [31:0] vrs;
  logic [31:0] vrt;

  // ---------------------------------------------------------------------------
  // Data memory with clearing sweep
  // ---------------------------------------------------------------------------
  logic [31:0]       dmem [MEM_WORDS];
  logic [31:0]       mem_rdata_q;
  logic              clr_busy_q;
  logic [MEM_AW-1:0] clr_idx_q;
  logic              mem_we;
  logic              mem_re;
  logic [MEM_AW-1:0] mem_addr;
  logic [31:0]       mem_wdata;

  exec_t ex;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign s2_load     = !v2_q || !out_stall_i;
  assign s1_adv      = v1_q && s2_load;
  assign in_stall_o  = clr_busy_q || (v1_q && !s2_load);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = v2_q;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // ---------------------------------------------------------------------------
  // Operand fetch with forwarding. Priority: the S2 word about to write,
  // then the write of the previous edge, then the array (invalid reads zero).
  // ---------------------------------------------------------------------------
  assign rs1    = ins1_q[25:21];
  assign rt1    = ins1_q[20:16];
  assign wb_val = ld_q ? mem_rdata_q : value_q;
  assign rf_we  = fresh_q && wen_q;

  always_comb begin
    if (rs1 == REG_ZERO) begin
      vrs = '0;
    end else if (rf_we && widx_q == rs1) begin
      vrs = wb_val;
    end else if (lw_en_q && lw_idx_q == rs1) begin
      vrs = lw_data_q;
    end else if (rf_vld_q[rs1]) begin
      vrs = rf_a_q;
    end else begin
      vrs = '0;
    end

    if (rt1 == REG_ZERO) begin
      vrt = '0;
    end else if (rf_we && widx_q == rt1) begin
      vrt = wb_val;
    end else if (lw_en_q && lw_idx_q == rt1) begin
      vrt = lw_data_q;
    end else if (rf_vld_q[rt1]) begin
      vrt = rf_b_q;
    end else begin
      vrt = '0;
    end
  end

  // Read for whichever word occupies S1 next cycle; refresh every cycle.
  assign rf_ra = in_acc ? instruction_i[25:21] : rs1;
  assign rf_rb = in_acc ? instruction_i[20:16] : rt1;

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[widx_q] <= wb_val;
    end
    rf_a_q <= rf_mem[rf_ra];
    rf_b_q <= rf_mem[rf_rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      lw_en_q  <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_vld_q[widx_q] <= 1'b1;
      end
      lw_en_q <= rf_we;
    end
  end

  always_ff @(posedge clk_i) begin
    lw_idx_q  <= widx_q;
    lw_data_q <= wb_val;
  end

  // ---------------------------------------------------------------------------
  // Execute
  // ---------------------------------------------------------------------------
  mse_exec u_exec (
    .ins_i  (ins1_q),
    .pc_i   (pc_q),
    .vrs_i  (vrs),
    .vrt_i  (vrt),
    .pend_i (pend_q),
    .btgt_i (btgt_q),
    .exec_o (ex)
  );

  // ---------------------------------------------------------------------------
  // Data memory port: sweep after reset, else the S1 word's load or store
  // ---------------------------------------------------------------------------
  assign mem_we    = clr_busy_q || (s1_adv && ex.st);
  assign mem_re    = s1_adv && ex.rd_mem;
  assign mem_addr  = clr_busy_q ? clr_idx_q : ex.ea[MEM_AW+1:2];
  assign mem_wdata = clr_busy_q ? '0 : ex.sdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dmem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= dmem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == MEM_AW'(MEM_WORDS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control and architectural state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      fresh_q <= 1'b0;
      pc_q    <= '0;
      pend_q  <= 1'b0;
      btgt_q  <= '0;
    end else begin
      // advance S1 when filled, drop it when it moves on
      if (in_acc) begin
        v1_q <= 1'b1;
      end else if (s1_adv) begin
        v1_q <= 1'b0;
      end
      if (s2_load) begin
        v2_q <= v1_q;
      end
      fresh_q <= s1_adv;

      if (cfg_we) begin
        pc_q <= cfg_start_pc_i;
      end else if (s1_adv) begin
        pc_q   <= ex.pc_nxt;
        pend_q <= ex.pend_nxt;
        btgt_q <= ex.btgt_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ins1_q <= instruction_i;
    end
    if (s1_adv) begin
      status_q   <= ex.err;
      pc_after_q <= ex.pc_nxt;
      wen_q      <= ex.wen;
      widx_q     <= ex.widx;
      value_q    <= ex.wval;
      ld_q       <= ex.ld;
      st_q       <= ex.st;
      maddr_q    <= ex.st ? ex.ea : '0;
      mdata_q    <= ex.st ? ex.sdata : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result word
  // ---------------------------------------------------------------------------
  assign status_o      = status_q;
  assign pc_after_o    = pc_after_q;
  assign reg_written_o = wen_q;
  assign reg_index_o   = widx_q;
  assign reg_value_o   = wb_val;
  assign mem_written_o = st_q;
  assign mem_address_o = maddr_q;
  assign mem_data_o    = mdata_q;

`ifndef SYNTHESIS
  a_no_r0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> (widx_q != REG_ZERO))
    else $error("register write aimed at r0");

  a_fresh_in_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q |-> v2_q)
    else $error("pending register write without a result word");

  a_err_no_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && status_q) |-> (!wen_q && !st_q))
    else $error("faulting access changed state");

  a_sweep_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (!v1_q && !v2_q))
    else $error("instruction in flight during memory sweep");

  a_slot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && s1_adv && !ex.err && !cfg_we) |=> !pend_q)
    else $error("delay slot left the branch armed");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mse_pkg::*;

  // Longest run of cycles with no handshake on any channel. The memory sweep
  // after reset and the long receiver hold both fit well inside it.
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 200;

  // One retired instruction as the core reports it.
  typedef struct packed {
    logic        status;
    logic [31:0] pc_after;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [31:0] mem_address;
    logic [31:0] mem_data;
  } retire_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] instruction_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        status_o;
  logic [31:0] pc_after_o;
  logic        reg_written_o;
  logic [4:0]  reg_index_o;
  logic [31:0] reg_value_o;
  logic        mem_written_o;
  logic [31:0] mem_address_o;
  logic [31:0] mem_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_start_pc_i;

  // Architectural state of the core as the testbench tracks it.
  logic [31:0] gpr [32];
  logic [31:0] dmem [MEM_WORDS];
  logic [31:0] pc_q;
  logic        slot_armed_q;
  logic [31:0] slot_target_q;

  retire_t     retire_q [$];
  int unsigned fail_count;

  // Traffic shaping knobs shared by the stimulus and the receiver.
  logic        sender_idle;
  logic        recv_idle;
  int unsigned hold_len;

  mips_subset_execute_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .instruction_i  (instruction_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .pc_after_o     (pc_after_o),
    .reg_written_o  (reg_written_o),
    .reg_index_o    (reg_index_o),
    .reg_value_o    (reg_value_o),
    .mem_written_o  (mem_written_o),
    .mem_address_o  (mem_address_o),
    .mem_data_o     (mem_data_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_start_pc_i (cfg_start_pc_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Instruction encoders
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] r_word(input logic [4:0] rs, rt, rd, sa,
                                         input logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs, rt,
                                         input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] j_word(input logic [5:0] op, input logic [25:0] tgt);
    return {op, tgt};
  endfunction

  // ---------------------------------------------------------------------------
  // Execution model: compute the retire record of one word and update the
  // tracked architectural state.
  // ---------------------------------------------------------------------------

  task automatic clear_arch_state();
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    for (int i = 0; i < int'(MEM_WORDS); i++) dmem[i] = '0;
    pc_q          = '0;
    slot_armed_q  = 1'b0;
    slot_target_q = '0;
  endtask

  task automatic execute_insn(input logic [31:0] w);
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [4:0]  widx;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] simm;
    logic [31:0] ea;
    logic [31:0] val;
    logic [31:0] dest;
    logic [31:0] cur;
    logic        wr;
    logic        taken;
    logic        st;
    retire_t     r;
    op    = w[31:26];
    rs    = w[25:21];
    rt    = w[20:16];
    rd    = w[15:11];
    sa    = w[10:6];
    fn    = w[5:0];
    a     = gpr[rs];
    b     = gpr[rt];
    simm  = {{16{w[15]}}, w[15:0]};
    ea    = a + simm;
    cur   = pc_q;
    wr    = 1'b0;
    taken = 1'b0;
    st    = 1'b0;
    widx  = rd;
    val   = '0;
    dest  = '0;
    r     = '0;

    case (op)
      OP_SPECIAL: begin
        wr = 1'b1;
        case (fn)
          FN_SLL: begin
            // all-zero shift of r0 into r0 is the canonical NOP
            val = b << sa;
            wr  = |{rd, rt, sa};
          end
          FN_SRL:  val = b >> sa;
          FN_SRA:  val = $signed(b) >>> sa;
          FN_JR: begin
            wr    = 1'b0;
            taken = 1'b1;
            dest  = a;
          end
          FN_JALR: begin
            widx  = (rd == REG_ZERO) ? REG_RA : rd;
            val   = cur + 32'd8;
            taken = 1'b1;
            dest  = a;
          end
          FN_SUBU: val = a - b;
          FN_AND:  val = a & b;
          FN_OR:   val = a | b;
          FN_XOR:  val = a ^ b;
          FN_NOR:  val = ~(a | b);
          FN_SLT:  val = {31'd0, $signed(a) < $signed(b)};
          FN_SLTU: val = {31'd0, a < b};
          default: wr = 1'b0;
        endcase
      end
      OP_J, OP_JAL: begin
        taken = 1'b1;
        dest  = {cur[31:28], w[25:0], 2'b00};
        if (op == OP_JAL) begin
          wr   = 1'b1;
          widx = REG_RA;
          val  = cur + 32'd8;
        end
      end
      OP_BEQ, OP_BNE: begin
        if ((a == b) == (op == OP_BEQ)) begin
          taken = 1'b1;
          dest  = cur + 32'd4 + (simm << 2);
        end
      end
      OP_ADDIU: begin
        wr   = 1'b1;
        widx = rt;
        val  = a + simm;
      end
      OP_ORI: begin
        wr   = 1'b1;
        widx = rt;
        val  = a | {16'h0000, w[15:0]};
      end
      OP_LUI: begin
        wr   = 1'b1;
        widx = rt;
        val  = {w[15:0], 16'h0000};
      end
      OP_LW: begin
        wr   = 1'b1;
        widx = rt;
        val  = dmem[ea[MEM_AW+1:2]];
      end
      OP_SW:   st = 1'b1;
      default: ;
    endcase

    if ((op == OP_LW || op == OP_SW) && ea[1:0] != 2'b00) begin
      // address error: nothing moves, a pending branch stays armed
      r.status   = 1'b1;
      r.pc_after = cur;
    end else begin
      if (wr && widx != REG_ZERO) begin
        gpr[widx]     = val;
        r.reg_written = 1'b1;
        r.reg_index   = widx;
        r.reg_value   = val;
      end
      if (st) begin
        dmem[ea[MEM_AW+1:2]] = b;
        r.mem_written = 1'b1;
        r.mem_address = ea;
        r.mem_data    = b;
      end
      if (slot_armed_q) begin
        // delay slot retires: redirect, and any branch in it is dropped
        pc_q         = slot_target_q;
        slot_armed_q = 1'b0;
      end else begin
        pc_q = cur + 32'd4;
        if (taken) begin
          slot_armed_q  = 1'b1;
          slot_target_q = dest;
        end
      end
      r.pc_after = pc_q;
    end
    retire_q.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Random instruction source
  // ---------------------------------------------------------------------------

  // Favor a few low registers so results feed later operands.
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] random_insn();
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [5:0]  fn;
    logic [15:0] imm;
    int unsigned pick;
    rs   = pick_reg();
    rt   = pick_reg();
    rd   = pick_reg();
    imm  = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // raw noise: unknown opcodes and functs, every bit pattern
      return $urandom;
    end else if (pick < 38) begin
      case ($urandom_range(0, 9))
        0:       fn = FN_SLL;
        1:       fn = FN_SRL;
        2:       fn = FN_SRA;
        3:       fn = FN_SUBU;
        4:       fn = FN_AND;
        5:       fn = FN_OR;
        6:       fn = FN_XOR;
        7:       fn = FN_NOR;
        8:       fn = FN_SLT;
        default: fn = FN_SLTU;
      endcase
      return r_word(rs, rt, rd, 5'($urandom), fn);
    end else if (pick < 55) begin
      case ($urandom_range(0, 2))
        0:       return i_word(OP_ADDIU, rs, rt, imm);
        1:       return i_word(OP_ORI, rs, rt, imm);
        default: return i_word(OP_LUI, rs, rt, imm);
      endcase
    end else if (pick < 77) begin
      // loads and stores: mostly aligned, concentrated on a small window so
      // loads hit earlier stores; some with any base to reach the wrap
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
        rs  = REG_ZERO;
        imm = {14'($urandom_range(0, 63)), 2'b00};
      end else if (pick < 17) begin
        imm[1:0] = 2'd0 - gpr[rs][1:0];
      end
      return i_word(($urandom_range(0, 1) == 0) ? OP_LW : OP_SW, rs, rt, imm);
    end else begin
      if ($urandom_range(0, 2) == 0) rt = rs;
      case ($urandom_range(0, 5))
        0:       return i_word(OP_BEQ, rs, rt, imm);
        1:       return i_word(OP_BNE, rs, rt, imm);
        2:       return j_word(OP_J, 26'($urandom));
        3:       return j_word(OP_JAL, 26'($urandom));
        4:       return r_word(rs, REG_ZERO, REG_ZERO, REG_ZERO, FN_JR);
        default: return r_word(rs, REG_ZERO, rd, REG_ZERO, FN_JALR);
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offer one word, hold it while stalled, and predict it once it is taken.
  // Returns at the rising edge that accepted the word.
  task automatic send_word(input logic [31:0] w);
    int unsigned gap;
    gap = 0;
    if (sender_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    instruction_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    execute_insn(w);
  endtask

  // Drop valid and wait until every predicted word has retired.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (retire_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic load_start_pc(input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_start_pc_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    pc_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: random stall bursts, or one long hold when the stimulus asks
  // for it. Count the hold here so the sender keeps pushing meanwhile.
  initial begin : receiver
    int unsigned burst;
    forever begin
      @(negedge clk_i);
      if (hold_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
        out_stall_i <= 1'b0;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 8);
        out_stall_i <= 1'b1;
        repeat (burst) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Compare every taken result word with the oldest prediction.
  always @(posedge clk_i) begin : check_retire
    retire_t exp_r;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (retire_q.size() == 0) begin
        $error("result word with no instruction outstanding");
        fail_count++;
      end else begin
        exp_r = retire_q.pop_front();
        check_field("status", 32'(exp_r.status), 32'(status_o));
        check_field("pc_after", exp_r.pc_after, pc_after_o);
        check_field("reg_written", 32'(exp_r.reg_written), 32'(reg_written_o));
        check_field("reg_index", 32'(exp_r.reg_index), 32'(reg_index_o));
        check_field("reg_value", exp_r.reg_value, reg_value_o);
        check_field("mem_written", 32'(exp_r.mem_written), 32'(mem_written_o));
        check_field("mem_address", exp_r.mem_address, mem_address_o);
        check_field("mem_data", exp_r.mem_data, mem_data_o);
      end
    end
  end

  // Abort when no channel has moved a word for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("mips_subset_execute_core regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Operand extremes, every ALU and immediate op, r0 writes, NOP, unknown
  // codes, and loads and stores including the wrap and address errors.
  task automatic test_alu_and_memory();
    send_word(i_word(OP_LUI, REG_ZERO, 5'd1, 16'hFFFF));
    send_word(i_word(OP_ORI, 5'd1, 5'd1, 16'hFFFF));          // r1 = all ones
    send_word(i_word(OP_ADDIU, REG_ZERO, 5'd2, 16'h8000));    // r2 = most negative imm
    send_word(i_word(OP_ADDIU, REG_ZERO, 5'd3, 16'h7FFF));
    send_word(r_word(REG_ZERO, 5'd1, 5'd4, 5'd31, FN_SLL));
    send_word(r_word(REG_ZERO, 5'd1, 5'd5, 5'd31, FN_SRL));
    send_word(r_word(REG_ZERO, 5'd2, 5'd6, 5'd31, FN_SRA));
    send_word(r_word(REG_ZERO, 5'd1, 5'd7, REG_ZERO, FN_SUBU));
    send_word(r_word(5'd1, 5'd3, 5'd8, REG_ZERO, FN_AND));
    send_word(r_word(5'd2, 5'd3, 5'd9, REG_ZERO, FN_OR));
    send_word(r_word(5'd1, 5'd2, 5'd10, REG_ZERO, FN_XOR));
    send_word(r_word(REG_ZERO, REG_ZERO, 5'd11, REG_ZERO, FN_NOR));
    send_word(r_word(5'd2, 5'd3, 5'd12, REG_ZERO, FN_SLT));
    send_word(r_word(5'd2, 5'd3, 5'd13, REG_ZERO, FN_SLTU));
    send_word(32'h0000_0000);                                 // NOP
    send_word(i_word(OP_ADDIU, 5'd1, REG_ZERO, 16'h0005));    // r0 write dropped
    // store to the top of the address space, read back through the wrap
    send_word(i_word(OP_SW, 5'd2, 5'd1, 16'h7FFC));
    send_word(i_word(OP_LW, REG_ZERO, 5'd14, 16'hFFFC));
    send_word(i_word(OP_LW, REG_ZERO, 5'd15, 16'h0001));      // unaligned load
    send_word(i_word(OP_SW, REG_ZERO, 5'd1, 16'h0002));       // unaligned store
    send_word(32'hFFFF_FFFF);                                 // unknown opcode
    send_word(r_word(5'd1, 5'd1, 5'd16, 5'd1, 6'h3F));        // unknown funct
  endtask

  // Taken and untaken branches, jumps and links, and branches placed in the
  // delay slot, including an address error there.
  task automatic test_control_flow();
    send_word(i_word(OP_BEQ, REG_ZERO, REG_ZERO, 16'h0003));
    send_word(j_word(OP_JAL, 26'h000_0010));                  // in slot: link only
    send_word(i_word(OP_BNE, REG_ZERO, REG_ZERO, 16'hFFFF));  // not taken
    send_word(r_word(5'd3, REG_ZERO, REG_ZERO, REG_ZERO, FN_JALR));
    send_word(i_word(OP_LW, REG_ZERO, 5'd16, 16'h0001));      // slot stays armed
    send_word(i_word(OP_ADDIU, REG_ZERO, 5'd16, 16'h0001));
    send_word(j_word(OP_J, 26'h3FF_FFFF));
    send_word(r_word(5'd1, REG_ZERO, REG_ZERO, REG_ZERO, FN_JR));
    send_word(i_word(OP_BNE, 5'd1, REG_ZERO, 16'h8000));
    send_word(r_word(5'd2, REG_ZERO, 5'd20, REG_ZERO, FN_JALR));
    send_word(r_word(5'd1, REG_ZERO, REG_ZERO, REG_ZERO, FN_JR));
    send_word(32'h0000_0000);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) send_word(random_insn());
  endtask

  // Hold the result side long enough that the core backs up into the
  // instruction channel, while words keep coming.
  task automatic test_backpressure();
    hold_len = HOLD_CYCLES;
    repeat (40) send_word(random_insn());
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    instruction_i  = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_start_pc_i = '0;
    sender_idle    = 1'b1;
    recv_idle      = 1'b1;
    hold_len       = 0;
    fail_count     = 0;
    clear_arch_state();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // start just below the top so the pc wraps during the directed part
    load_start_pc(32'hFFFF_FFF8);
    test_alu_and_memory();
    test_control_flow();
    drain();

    load_start_pc(32'h0000_0000);
    test_random_traffic(300);
    drain();

    load_start_pc(32'hFFFF_FFFF);
    test_backpressure();
    test_random_traffic(260);
    drain();

    // closing stretch at full rate on both sides
    sender_idle = 1'b0;
    recv_idle   = 1'b0;
    load_start_pc($urandom);
    test_random_traffic(300);
    drain();

    if (fail_count == 0) begin
      $display("mips_subset_execute_core regression: pass");
    end else begin
      $display("mips_subset_execute_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: mips_subset_execute_core.f
src/mse_pkg.sv
src/mse_exec.sv
src/mips_subset_execute_core.sv
tb/sv/testbench.sv
